// ----- sv/prefix_code_bit_packer_assert.svh -----
// Assertion macros for the prefix code bit packer.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef PREFIX_CODE_BIT_PACKER_ASSERT_SVH
`define PREFIX_CODE_BIT_PACKER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define PCBP_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define PCBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PCBP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pcbp_pkg.sv -----
// Shared types and constants of the prefix code bit packer.
// No dependencies.
package pcbp_pkg;

    localparam int MAX_CODE_LEN     = 8;
    localparam int SYMBOL_COUNT_DEF = 4;
    localparam int SYMBOL_MAX       = 4;   // table size the symbol field can address
    localparam int QUEUE_DEPTH      = 4;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 4;
    localparam int FILL_W  = 3;
    localparam int TOTAL_W = 24;
    localparam int SYM_W   = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [LEN_W-1:0]   LEN_CAP   =
        LEN_W'((MAX_CODE_LEN < BYTE_W) ? MAX_CODE_LEN : BYTE_W);

    // Reset code table: a = 100, b = 11, c = 101, d = 0
    localparam logic [BYTE_W-1:0] CODE_WORD_RST [SYMBOL_MAX] = '{8'd4, 8'd3, 8'd5, 8'd0};
    localparam logic [LEN_W-1:0]  CODE_LEN_RST  [SYMBOL_MAX] = '{4'd3, 4'd2, 4'd3, 4'd1};

    // Register index: word of symbol k at 2k, length at 2k+1
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_BASE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_BASE  = 4'd1;

    // One queued item: what the back end has to emit for it.
    typedef struct packed {
        logic                 full_v;     // a byte was completed
        logic [BYTE_W-1:0]    full_byte;
        logic                 fin;        // final item, flush
        logic                 rem_v;      // bits still pending after packing
        logic [BYTE_W-1:0]    rem_byte;
        logic [TOTAL_W-1:0]   total;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- sv/pcbp_front.sv -----
// Front end: code table registers, bit packing state, per-item record build.
// Depends on pcbp_pkg.
module pcbp_front #(
    parameter int SYMBOL_COUNT = pcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pcbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [pcbp_pkg::SYM_W-1:0]      i_symbol,
    input  logic                            i_final_req,
    input  pcbp_pkg::t_q_status             i_q_status,
    output logic                            o_push,
    output pcbp_pkg::t_rec                  o_rec
);
    import pcbp_pkg::*;

    logic [BYTE_W-1:0]  r_code_word [SYMBOL_COUNT];
    logic [LEN_W-1:0]   r_code_len  [SYMBOL_COUNT];
    logic [BYTE_W-1:0]  r_partial;
    logic [FILL_W-1:0]  r_fill;
    logic [TOTAL_W-1:0] r_total;

    logic [BYTE_W-1:0]  n_partial;
    logic [FILL_W-1:0]  n_fill;
    logic [TOTAL_W-1:0] n_total;

    logic [BYTE_W-1:0]  raw_word;
    logic [LEN_W-1:0]   raw_len;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W:0]    len_mask;
    logic [BYTE_W-1:0]  word_m;
    logic [LEN_W-1:0]   fill_sum;
    logic [2*BYTE_W-1:0] comb_bits;
    logic [TOTAL_W:0]   total_sum;
    logic               accept;

    // Code table
    for (genvar k = 0; k < SYMBOL_COUNT; k++) begin : g_tab
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_code_word[k] <= CODE_WORD_RST[k];
                r_code_len[k]  <= CODE_LEN_RST[k];
            end else if (i_cfg_we) begin
                if (i_cfg_index == CFG_IDX_W'(2 * k) + CFG_WORD_BASE) begin
                    r_code_word[k] <= i_cfg_data;
                end
                if (i_cfg_index == CFG_IDX_W'(2 * k) + CFG_LEN_BASE) begin
                    r_code_len[k] <= i_cfg_data[LEN_W-1:0];
                end
            end
        end
    end

    // Symbols at or above SYMBOL_COUNT add no bits
    always_comb begin
        raw_word = '0;
        raw_len  = '0;
        for (int k = 0; k < SYMBOL_COUNT; k++) begin
            if (i_symbol == SYM_W'(k)) begin
                raw_word = r_code_word[k];
                raw_len  = r_code_len[k];
            end
        end
    end

    assign len       = (raw_len > LEN_CAP) ? LEN_CAP : raw_len;
    assign len_mask  = (BYTE_W+1)'((BYTE_W+1)'(1) << len) - (BYTE_W+1)'(1);
    assign word_m    = raw_word & len_mask[BYTE_W-1:0];
    assign fill_sum  = LEN_W'(r_fill) + len;
    // Pending bits sit at the top of a 16-bit window, new code goes right below them
    assign comb_bits = {r_partial, {BYTE_W{1'b0}}} |
                       ((2*BYTE_W)'(word_m) << (5'd16 - 5'(r_fill) - 5'(len)));
    assign total_sum = (TOTAL_W+1)'(r_total) + (TOTAL_W+1)'(len);

    always_comb begin
        o_rec.full_v    = fill_sum[FILL_W];
        o_rec.full_byte = comb_bits[2*BYTE_W-1:BYTE_W];
        o_rec.fin       = i_final_req;
        o_rec.rem_v     = (fill_sum[FILL_W-1:0] != '0);
        o_rec.rem_byte  = fill_sum[FILL_W] ? comb_bits[BYTE_W-1:0]
                                           : comb_bits[2*BYTE_W-1:BYTE_W];
        o_rec.total     = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    end

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && (o_rec.full_v || o_rec.fin);

    always_comb begin
        n_partial = r_partial;
        n_fill    = r_fill;
        n_total   = r_total;
        if (accept) begin
            if (i_final_req) begin
                n_partial = '0;
                n_fill    = '0;
                n_total   = '0;
            end else begin
                n_partial = o_rec.rem_byte;
                n_fill    = fill_sum[FILL_W-1:0];
                n_total   = o_rec.total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_fill    <= '0;
            r_total   <= '0;
        end else begin
            r_partial <= n_partial;
            r_fill    <= n_fill;
            r_total   <= n_total;
        end
    end

endmodule

// ----- sv/pcbp_fifo.sv -----
// Short record queue between the front and back ends.
// Depends on pcbp_pkg and prefix_code_bit_packer_assert.svh.
module pcbp_fifo #(
    parameter int DEPTH = pcbp_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  pcbp_pkg::t_rec       i_rec,
    input  logic                 i_pop,
    output pcbp_pkg::t_rec       o_head,
    output pcbp_pkg::t_q_status  o_status
);
    import pcbp_pkg::*;
    `include "prefix_code_bit_packer_assert.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_rec              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    `PCBP_ASSERT(a_no_overflow, !(i_push && o_status.full), "push into full queue")
    `PCBP_ASSERT(a_no_underflow, !(i_pop && o_status.empty), "pop from empty queue")
    `PCBP_ASSERT_NXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + CNT_W'(1),
        "queue count did not follow push")

endmodule

// ----- sv/pcbp_back.sv -----
// Back end: turns queued records into one or two results through an output register.
// Depends on pcbp_pkg and prefix_code_bit_packer_assert.svh.
module pcbp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcbp_pkg::t_rec                i_head,
    input  pcbp_pkg::t_q_status           i_q_status,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pcbp_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_byte_valid,
    output logic [pcbp_pkg::TOTAL_W-1:0]  o_total_bits,
    output logic                          o_last
);
    import pcbp_pkg::*;
    `include "prefix_code_bit_packer_assert.svh"

    logic               r_out_valid;
    logic               r_second;     // flushed remainder of a two-result item is next
    logic [BYTE_W-1:0]  r_byte;
    logic               r_byte_valid;
    logic [TOTAL_W-1:0] r_total;
    logic               r_last;

    logic               load;
    logic               two;
    logic [BYTE_W-1:0]  sel_byte;
    logic               sel_bv;
    logic               sel_last;

    assign load = !i_q_status.empty && (!r_out_valid || i_out_ready);
    assign two  = i_head.full_v && i_head.fin && i_head.rem_v;

    always_comb begin
        if (r_second) begin
            sel_byte = i_head.rem_byte;
            sel_bv   = 1'b1;
            sel_last = 1'b1;
        end else if (i_head.full_v) begin
            sel_byte = i_head.full_byte;
            sel_bv   = 1'b1;
            sel_last = i_head.fin && !i_head.rem_v;
        end else if (i_head.rem_v) begin
            sel_byte = i_head.rem_byte;
            sel_bv   = 1'b1;
            sel_last = 1'b1;
        end else begin
            // final item with nothing pending
            sel_byte = '0;
            sel_bv   = 1'b0;
            sel_last = 1'b1;
        end
    end

    assign o_pop = load && (r_second || !two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_second    <= !r_second && two;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte       <= sel_byte;
            r_byte_valid <= sel_bv;
            r_total      <= i_head.total;
            r_last       <= sel_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_total_bits = r_total;
    assign o_last       = r_last;

    `PCBP_ASSERT_IMP(a_second_has_out, r_second, r_out_valid,
        "remainder pending without a result in the output register")
    `PCBP_ASSERT_IMP(a_first_not_last, $rose(r_second), !r_last,
        "first of two results flagged last")
    `PCBP_ASSERT_NXT(a_second_is_last, r_second && load, r_last && r_byte_valid,
        "flushed remainder not flagged last")

endmodule

// ----- sv/prefix_code_bit_packer.sv -----
// Top level of the prefix code bit packer.
// Depends on pcbp_pkg, pcbp_front, pcbp_fifo and pcbp_back.

// Encodes one symbol per item with a programmable prefix code (up to 8 bits per
// symbol) and packs the bits MSB-first into bytes. An item is taken every cycle
// while the four-entry record queue has room; the packing state updates in the
// same cycle. Results leave through a registered output, one per cycle while the
// output is taken: an item gives no result, one byte, or on a final item up to two
// results (full byte plus the zero-padded remainder, or a single byte_valid=0
// marker carrying the count). A final item that both completes a byte and leaves
// bits pending stays in the queue until its second result is loaded. Code table
// registers are written at index 2k (word) and 2k+1 (length) for symbol k; writes
// take effect on the next cycle and must happen while the block is idle.
module prefix_code_bit_packer #(
    parameter int SYMBOL_COUNT = pcbp_pkg::SYMBOL_COUNT_DEF,
    parameter int QUEUE_DEPTH  = pcbp_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pcbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [pcbp_pkg::SYM_W-1:0]      i_symbol,
    input  logic                            i_final_req,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [pcbp_pkg::BYTE_W-1:0]     o_out_byte,
    output logic                            o_byte_valid,
    output logic [pcbp_pkg::TOTAL_W-1:0]    o_total_bits,
    output logic                            o_last
);
    import pcbp_pkg::*;

    t_rec       push_rec;
    t_rec       head_rec;
    t_q_status  q_status;
    logic       push;
    logic       pop;

    pcbp_front #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_symbol    (i_symbol),
        .i_final_req (i_final_req),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    pcbp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (push_rec),
        .i_pop    (pop),
        .o_head   (head_rec),
        .o_status (q_status)
    );

    pcbp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_rec),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_total_bits (o_total_bits),
        .o_last       (o_last)
    );

endmodule
